>>> hdl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared constants, codes and control types for the UART receive buffer.
// ----------------------------------------------------------------------------
package urb_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int CHANNELS_DEF = 3;

  localparam int REQ_W    = 2;
  localparam int CH_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 7;
  localparam int MASK_W   = 3;
  localparam int MAX_READ = 64;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_FRAME_MODE_IDX = 1'b0;

  localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_IDLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic emit_data;
    logic emit_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic n_zero;
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

>>> hdl/urb_req_if.sv
// ----------------------------------------------------------------------------
// urb_req_if
// Request channel: received bytes, idle-line events and read requests.
// ----------------------------------------------------------------------------
interface urb_req_if;
  import urb_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] rx_byte;
  logic [CNT_W-1:0]  max_count;

  modport source (output valid, output req_type, output channel, output rx_byte,
                  output max_count, input ready);
  modport sink (input valid, input req_type, input channel, input rx_byte,
                input max_count, output ready);
endinterface

>>> hdl/urb_rsp_if.sv
// ----------------------------------------------------------------------------
// urb_rsp_if
// Result channel: one returned byte, or an empty-read marker, per item.
// ----------------------------------------------------------------------------
interface urb_rsp_if;
  import urb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              last_of_read;

  modport source (output valid, output out_channel, output data_byte,
                  output byte_valid, output last_of_read, input ready);
  modport sink (input valid, input out_channel, input data_byte,
                input byte_valid, input last_of_read, output ready);
endinterface

>>> hdl/uart_rx_ring_and_frame_buffer_core.sv
// Byte and idle-line items are accepted, then make one store write or update.
// A read is accepted and starts on the registered read port of the selected byte
// store; results enter the output register one per cycle while the sink is ready.
// Reads stream one byte per cycle off that read port while the sink is ready.
// Synchronous reset clears pointers, fill counts, frame lengths and the mode mask;
// the byte stores are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// uart_rx_ring_and_frame_buffer_core
// Multi-channel UART receive buffer with ring and ping-pong frame modes.
// ----------------------------------------------------------------------------
module uart_rx_ring_and_frame_buffer_core #(
  parameter int DEPTH    = urb_pkg::DEPTH_DEF,
  parameter int CHANNELS = urb_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  urb_req_if.sink                     req,
  urb_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urb_pkg::PADDR_W-1:0] paddr,
  input  logic [urb_pkg::PDATA_W-1:0] pwdata,
  output logic [urb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import urb_pkg::*;

  logic [MASK_W-1:0] frame_mode_mask;
  logic              reg_sel;
  logic              in_ready;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign reg_sel = (paddr[PADDR_W-1] == REG_FRAME_MODE_IDX);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(frame_mode_mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode_mask <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_mode_mask <= pwdata[MASK_W-1:0];
    end
  end

  assign req.ready = in_ready;

  urb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  urb_datapath #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .frame_mode_mask (frame_mode_mask),
    .in_req_type     (req.req_type),
    .in_channel      (req.channel),
    .in_rx_byte      (req.rx_byte),
    .in_max_count    (req.max_count),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_channel     (rsp.out_channel),
    .data_byte       (rsp.data_byte),
    .byte_valid      (rsp.byte_valid),
    .last_of_read    (rsp.last_of_read)
  );

endmodule

>>> hdl/urb_ctrl.sv
// ----------------------------------------------------------------------------
// urb_ctrl
// Sequencer: takes an item, runs it through the datapath and paces reads.
// ----------------------------------------------------------------------------
module urb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  urb_pkg::dp_sts_t sts,
  output urb_pkg::dp_cmd_t cmd
);
  import urb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.is_read) begin
          state_next = ST_IDLE;
        end else if (sts.n_zero) begin
          state_next = ST_EMPTY;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/urb_datapath.sv
// ----------------------------------------------------------------------------
// urb_datapath
// Per-channel pointers and lengths, the two byte stores and the result register.
// ----------------------------------------------------------------------------
module urb_datapath #(
  parameter int DEPTH    = urb_pkg::DEPTH_DEF,
  parameter int CHANNELS = urb_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  urb_pkg::dp_cmd_t            cmd,
  output urb_pkg::dp_sts_t            sts,
  input  logic [urb_pkg::MASK_W-1:0]  frame_mode_mask,
  input  logic [urb_pkg::REQ_W-1:0]   in_req_type,
  input  logic [urb_pkg::CH_W-1:0]    in_channel,
  input  logic [urb_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic [urb_pkg::CNT_W-1:0]   in_max_count,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [urb_pkg::CH_W-1:0]    out_channel,
  output logic [urb_pkg::BYTE_W-1:0]  data_byte,
  output logic                        byte_valid,
  output logic                        last_of_read
);
  import urb_pkg::*;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW        = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  logic [REQ_W-1:0]  item_req;
  logic [CH_W-1:0]   item_ch;
  logic [BYTE_W-1:0] item_byte;
  logic [CNT_W-1:0]  item_maxc;
  logic [AW-1:0]     item_base;

  logic [PTR_W-1:0]  head   [CHANNELS];
  logic [PTR_W-1:0]  tail   [CHANNELS];
  logic [FILL_W-1:0] fill   [CHANNELS];
  logic [FILL_W-1:0] len_a  [CHANNELS];
  logic [FILL_W-1:0] len_b  [CHANNELS];
  logic              act_b  [CHANNELS];

  logic [BYTE_W-1:0] mem_a  [MEM_DEPTH];
  logic [BYTE_W-1:0] mem_b  [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_a;
  logic [BYTE_W-1:0] rdata_b;

  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  rem;
  logic              rd_sel_b;

  logic              ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [MASK_W:0]   mask_ext;
  logic              mode_frame;
  logic [PTR_W-1:0]  cur_head;
  logic [PTR_W-1:0]  cur_tail;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] cur_len_a;
  logic [FILL_W-1:0] cur_len_b;
  logic              cur_act_b;
  logic [PTR_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W:0]    occ;
  logic [CNT_W-1:0]  maxc_c;
  logic [FILL_W-1:0] frame_len;
  logic [LW-1:0]     avail;
  logic [CNT_W-1:0]  n;
  logic [LW:0]       hsum;
  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  start_idx;
  logic              fill_room;

  logic              we_a;
  logic              we_b;
  logic [AW-1:0]     waddr;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic [AW-1:0]     raddr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_req  <= in_req_type;
      item_ch   <= in_channel;
      item_byte <= in_rx_byte;
      item_maxc <= in_max_count;
      item_base <= AW'(32'(in_channel) * DEPTH);
    end
  end

  assign ch_ok      = (32'(item_ch) < CHANNELS);
  assign ch_idx     = CH_IDX_W'(item_ch);
  assign mask_ext   = {1'b0, frame_mode_mask};
  assign mode_frame = mask_ext[item_ch];

  always_comb begin
    cur_head  = '0;
    cur_tail  = '0;
    cur_fill  = '0;
    cur_len_a = '0;
    cur_len_b = '0;
    cur_act_b = 1'b0;
    if (ch_ok) begin
      cur_head  = head[ch_idx];
      cur_tail  = tail[ch_idx];
      cur_fill  = fill[ch_idx];
      cur_len_a = len_a[ch_idx];
      cur_len_b = len_b[ch_idx];
      cur_act_b = act_b[ch_idx];
    end
  end

  assign tail_inc = (cur_tail == PTR_W'(DEPTH - 1)) ? '0 : cur_tail + 1'b1;
  assign head_inc = (cur_head == PTR_W'(DEPTH - 1)) ? '0 : cur_head + 1'b1;

  assign occ = (cur_tail >= cur_head) ? ({1'b0, cur_tail} - {1'b0, cur_head})
             : ({1'b0, cur_tail} + (PTR_W+1)'(DEPTH) - {1'b0, cur_head});

  assign maxc_c    = (item_maxc > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : item_maxc;
  assign frame_len = cur_act_b ? cur_len_a : cur_len_b;
  assign avail     = mode_frame ? LW'(frame_len) : LW'(occ);

  always_comb begin
    if (!ch_ok) begin
      n = '0;
    end else if (avail < LW'(maxc_c)) begin
      n = CNT_W'(avail);
    end else begin
      n = maxc_c;
    end
  end

  assign hsum      = (LW+1)'(cur_head) + (LW+1)'(n);
  assign head_adv  = (hsum >= (LW+1)'(DEPTH)) ? PTR_W'(hsum - (LW+1)'(DEPTH))
                   : PTR_W'(hsum);
  assign start_idx = mode_frame ? '0 : cur_head;
  assign fill_room = (cur_fill < FILL_W'(DEPTH));

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    waddr = item_base + AW'(cur_tail);
    if (cmd.exec && ch_ok && item_req == REQ_BYTE) begin
      if (mode_frame) begin
        waddr = item_base + AW'(cur_fill);
        if (fill_room) begin
          we_a = !cur_act_b;
          we_b = cur_act_b;
        end
      end else begin
        we_a = 1'b1;
      end
    end
  end

  always_comb begin
    rd_en  = 1'b0;
    rd_ptr = rptr;
    if (cmd.exec && item_req == REQ_READ && n != '0) begin
      rd_en  = 1'b1;
      rd_ptr = start_idx;
    end else if (cmd.emit_data && rem > CNT_W'(1)) begin
      rd_en = 1'b1;
    end
  end

  assign rd_ptr_inc = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign raddr      = item_base + AW'(rd_ptr);

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= item_byte;
    end
    if (rd_en) begin
      rdata_a <= mem_a[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= item_byte;
    end
    if (rd_en) begin
      rdata_b <= mem_b[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rptr <= rd_ptr_inc;
    end
    if (cmd.exec) begin
      rem      <= n;
      rd_sel_b <= mode_frame && !cur_act_b;
    end else if (cmd.emit_data) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        fill[c]  <= '0;
        len_a[c] <= '0;
        len_b[c] <= '0;
        act_b[c] <= 1'b0;
      end
    end else if (cmd.exec && ch_ok) begin
      case (item_req)
        REQ_BYTE: begin
          if (mode_frame) begin
            if (fill_room) begin
              fill[ch_idx] <= cur_fill + 1'b1;
            end
          end else begin
            tail[ch_idx] <= tail_inc;
            if (cur_head == tail_inc) begin
              head[ch_idx] <= head_inc;
            end
          end
        end
        REQ_IDLE: begin
          if (mode_frame) begin
            if (cur_act_b) begin
              len_b[ch_idx] <= cur_fill;
            end else begin
              len_a[ch_idx] <= cur_fill;
            end
            act_b[ch_idx] <= !cur_act_b;
            fill[ch_idx]  <= '0;
          end
        end
        REQ_READ: begin
          if (mode_frame) begin
            if (frame_len != '0) begin
              if (cur_act_b) begin
                len_a[ch_idx] <= '0;
              end else begin
                len_b[ch_idx] <= '0;
              end
            end
          end else begin
            head[ch_idx] <= head_adv;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_channel  <= item_ch;
      data_byte    <= rd_sel_b ? rdata_b : rdata_a;
      byte_valid   <= 1'b1;
      last_of_read <= (rem == CNT_W'(1));
    end else if (cmd.emit_empty) begin
      out_channel  <= item_ch;
      data_byte    <= '0;
      byte_valid   <= 1'b0;
      last_of_read <= 1'b1;
    end
  end

  assign sts.is_read  = (item_req == REQ_READ);
  assign sts.n_zero   = (n == '0);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.last     = (rem == CNT_W'(1));

`ifndef ASSERT_OFF
  a_emit_has_bytes: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_data |-> rem != '0)
    else $error("Data item emitted with no bytes left.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_data || cmd.emit_empty) |-> sts.out_free)
    else $error("Result register overwritten before it was taken.");

  a_no_emit_after_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !sts.is_read) |=> !(cmd.emit_data || cmd.emit_empty))
    else $error("Result produced for a non-read item.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ch_ok |-> (32'(cur_fill) <= DEPTH))
    else $error("Frame fill count beyond buffer depth.");
`endif

endmodule
